[design/ialu_pkg.sv]
package ialu_pkg;

  localparam int unsigned CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOP   = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_DIV   = 3'd4,
    CMD_PRIME = 3'd5,
    CMD_ODD   = 3'd6,
    CMD_NEG   = 3'd7
  } cmd_t;

  typedef struct packed {
    logic start;
  } eng_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_sts_t;

endpackage

[design/ialu_mul.sv]
module ialu_mul #(
  parameter int unsigned W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ialu_pkg::eng_ctl_t ctl,
  input  logic [W-1:0]       mcand,
  input  logic [W-1:0]       mplier,
  output ialu_pkg::eng_sts_t sts,
  output logic [W-1:0]       product
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  mcand_r;
  logic [W-1:0]  mplier_r;

  // one multiplier bit per cycle, shift and add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= CW'(W);
        acc_r    <= '0;
        mcand_r  <= mcand;
        mplier_r <= mplier;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[W-1:1]};
        cnt_r    <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;

endmodule

[design/ialu_div.sv]
module ialu_div #(
  parameter int unsigned W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ialu_pkg::eng_ctl_t ctl,
  input  logic [W-1:0]       dividend,
  input  logic [W-1:0]       divisor,
  output ialu_pkg::eng_sts_t sts,
  output logic [W-1:0]       quotient,
  output logic [W-1:0]       remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[design/integer_alu_with_prime_test.sv]
// path, input to output transfer: nop, add, sub, odd, negative, zero divisor and trivial prime
// cases go through res_r and the output register; mul and div wait on the bit-serial engines
// prime test: one divider pass per odd trial divisor
// flow: one item in work at a time; the next input transfer can coincide with the earliest
// output transfer, a stalled result waits in place
// reset: rst_n synchronous active low, clears state and valid flags
module integer_alu_with_prime_test #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ialu_pkg::CMD_W-1:0]   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_result,
  output logic                         out_div_by_zero
);

  localparam int unsigned W = DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_PRIME,
    S_DONE
  } state_t;

  state_t             state_r;
  logic               mul_start_r;
  logic               div_start_r;
  logic [W-1:0]       opa_r;
  logic [W-1:0]       opb_r;
  logic               neg_r;
  logic [W-1:0]       res_r;
  logic               dz_r;
  logic               out_valid_r;
  logic [W-1:0]       out_result_r;
  logic               out_dz_r;
  ialu_pkg::eng_ctl_t mul_ctl;
  ialu_pkg::eng_ctl_t div_ctl;
  ialu_pkg::eng_sts_t mul_sts;
  ialu_pkg::eng_sts_t div_sts;
  logic [W-1:0]       product;
  logic [W-1:0]       quotient;
  logic [W-1:0]       remainder;
  logic [W-1:0]       a_u;
  logic [W-1:0]       b_u;
  logic [W-1:0]       a_mag;
  logic [W-1:0]       b_mag;
  logic               in_xfer;
  logic               out_load;

  assign a_u      = in_operand_a;
  assign b_u      = in_operand_b;
  assign a_mag    = a_u[W-1] ? (W'(0) - a_u) : a_u;
  assign b_mag    = b_u[W-1] ? (W'(0) - b_u) : b_u;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign mul_ctl.start = mul_start_r;
  assign div_ctl.start = div_start_r;

  ialu_mul #(.W(W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .mcand   (opa_r),
    .mplier  (opb_r),
    .sts     (mul_sts),
    .product (product)
  );

  ialu_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (opa_r),
    .divisor   (opb_r),
    .sts       (div_sts),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_result_r <= res_r;
        out_dz_r     <= dz_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            dz_r    <= 1'b0;
            res_r   <= '0;
            state_r <= S_DONE;
            unique case (ialu_pkg::cmd_t'(in_cmd))
              ialu_pkg::CMD_NOP: res_r <= '0;
              ialu_pkg::CMD_ADD: res_r <= a_u + b_u;
              ialu_pkg::CMD_SUB: res_r <= a_u - b_u;
              ialu_pkg::CMD_MUL: begin
                opa_r       <= a_u;
                opb_r       <= b_u;
                mul_start_r <= 1'b1;
                state_r     <= S_MUL;
              end
              ialu_pkg::CMD_DIV: begin
                if (b_u == '0) begin
                  dz_r <= 1'b1;
                end else begin
                  opa_r       <= a_mag;
                  opb_r       <= b_mag;
                  neg_r       <= a_u[W-1] ^ b_u[W-1];
                  div_start_r <= 1'b1;
                  state_r     <= S_DIV;
                end
              end
              ialu_pkg::CMD_PRIME: begin
                priority if (a_u[W-1] || a_u <= W'(1)) begin
                  res_r <= '0;
                end else if (a_u == W'(2)) begin
                  res_r <= W'(1);
                end else if (!a_u[0]) begin
                  res_r <= '0;
                end else begin
                  opa_r       <= a_u;
                  opb_r       <= W'(3);
                  div_start_r <= 1'b1;
                  state_r     <= S_PRIME;
                end
              end
              ialu_pkg::CMD_ODD: res_r <= {{(W-1){1'b0}}, a_u[0]};
              ialu_pkg::CMD_NEG: res_r <= {{(W-1){1'b0}}, a_u[W-1]};
            endcase
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            res_r   <= product;
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_r   <= neg_r ? (W'(0) - quotient) : quotient;
            state_r <= S_DONE;
          end
        end
        S_PRIME: begin
          if (div_sts.done) begin
            priority if (quotient < opb_r) begin
              res_r   <= W'(1);
              state_r <= S_DONE;
            end else if (remainder == '0) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              opb_r       <= opb_r + W'(2);
              div_start_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_div_by_zero = out_dz_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> (out_result == '0))
    else $error("divide-by-zero result not zero");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input still ready after transfer");

  a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV || state_r == S_PRIME))
    else $error("divider finished outside a division");

  a_mul_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == S_MUL))
    else $error("multiplier finished outside a product");

  a_idle_engines: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
    else $error("engine busy while idle");

endmodule
